### hdl/rlms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlms_pkg
// types, register indexes and constants shared by the mode sequencer
// ----------------------------------------------------------------------------
package rlms_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_LED_FLASH_PERIOD   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEND_PERIOD        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ON_BIT_INDEX       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_RANGE_BIT_INDEX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_FLOOR     = 3'd4;

	localparam logic [15:0] RST_LED_FLASH_PERIOD = 16'd500;
	localparam logic [15:0] RST_SEND_PERIOD      = 16'd100;
	localparam logic [2:0]  RST_ON_BIT_INDEX     = 3'd0;
	localparam logic [2:0]  RST_IN_RANGE_BIT_IDX = 3'd1;
	localparam logic [9:0]  RST_THROTTLE_FLOOR   = 10'd370;

	localparam logic [10:0] SPEED_MAX = 11'd1024;

	localparam logic [2:0] LED_OFF_MASK   = 3'b001;
	localparam logic [2:0] LED_RANGE_MASK = 3'b010;
	localparam logic [2:0] LED_ON_MASK    = 3'b100;

	typedef enum logic [1:0] {
		MODE_OFF      = 2'd0,
		MODE_IN_RANGE = 2'd1,
		MODE_ON       = 2'd2
	} mode_t;

	typedef struct packed {
		logic [15:0] led_flash_period;
		logic [15:0] send_period;
		logic [2:0]  on_bit_index;
		logic [2:0]  in_range_bit_index;
		logic [9:0]  throttle_floor;
	} cfg_t;

	typedef struct packed {
		mode_t       mode;
		logic        entering;
		logic [15:0] flash_count;
		logic [15:0] send_count;
		logic        on_flag;
		logic [2:0]  leds;
	} state_t;

	typedef struct packed {
		logic [9:0] throttle_sample;
		logic       button_event;
		logic       link_timed_out;
		logic [7:0] reply_status;
		logic       reply_arrived;
	} tick_in_t;

	typedef struct packed {
		mode_t       mode_out;
		logic [2:0]  led_pattern;
		logic [10:0] motor_speed;
		logic [7:0]  status_out;
		logic        send_now;
	} tick_out_t;

endpackage

### hdl/remote_link_mode_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_link_mode_sequencer_top
// mode sequencer of a hand-held remote, one beat per main-loop tick
// ----------------------------------------------------------------------------
// Each input beat is one tick: reply flag and status, link timeout, button
// press and a 10-bit throttle sample. Each tick gives exactly one output
// beat: send flag, status byte, motor speed, LED pattern and the new mode.
// The beat is captured in an input register, the tick is evaluated
// combinationally against the mode state and the result lands in an
// output register, from which it leaves when the receiver takes it. One
// beat is taken every cycle while the output side keeps up.
// When the output receiver stalls, the output register holds its beat, the
// input register fills behind it and s_axis_tready drops; nothing is lost.
// Registers are to be written through cfg_we / cfg_index / cfg_wdata while
// idle; the block itself does not enforce it. Reset puts the block in off
// mode with counters cleared, all LEDs dark and registers at their defaults.
// ----------------------------------------------------------------------------
module remote_link_mode_sequencer_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// reply_arrived, reply_status, link_timed_out, button_event, throttle_sample
	input  logic [rlms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// send_now, status_out, motor_speed, led_pattern, mode_out
	output logic [rlms_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [rlms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rlms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import rlms_pkg::*;

	cfg_t      cfg_q;
	state_t    state_q;
	state_t    state_nxt;
	tick_in_t  tick_s1;
	logic      valid_s1;
	tick_out_t res_nxt;
	tick_out_t res_q;
	logic      out_valid_q;
	logic      advance;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_flash_period   <= RST_LED_FLASH_PERIOD;
			cfg_q.send_period        <= RST_SEND_PERIOD;
			cfg_q.on_bit_index       <= RST_ON_BIT_INDEX;
			cfg_q.in_range_bit_index <= RST_IN_RANGE_BIT_IDX;
			cfg_q.throttle_floor     <= RST_THROTTLE_FLOOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LED_FLASH_PERIOD:   cfg_q.led_flash_period   <= cfg_wdata;
				REG_SEND_PERIOD:        cfg_q.send_period        <= cfg_wdata;
				REG_ON_BIT_INDEX:       cfg_q.on_bit_index       <= cfg_wdata[2:0];
				REG_IN_RANGE_BIT_INDEX: cfg_q.in_range_bit_index <= cfg_wdata[2:0];
				REG_THROTTLE_FLOOR:     cfg_q.throttle_floor     <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1 <= tick_in_t'(s_axis_tdata[$bits(tick_in_t)-1:0]);
		end
	end

	rlms_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.tick (tick_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// mode state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_OFF;
			state_q.entering    <= 1'b1;
			state_q.flash_count <= '0;
			state_q.send_count  <= '0;
			state_q.on_flag     <= 1'b0;
			state_q.leds        <= '0;
			out_valid_q         <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - $bits(tick_out_t)){1'b0}}, res_q};

endmodule

### hdl/rlms_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlms_step
// next state and result of one main-loop tick
// ----------------------------------------------------------------------------
module rlms_step (
	input  rlms_pkg::cfg_t     cfg,
	input  rlms_pkg::state_t   cur,
	input  rlms_pkg::tick_in_t tick,
	output rlms_pkg::state_t   nxt,
	output rlms_pkg::tick_out_t res
);
	import rlms_pkg::*;

	logic [9:0]  diff;
	logic [12:0] diff_x7;
	logic [11:0] scaled;
	logic [10:0] speed;

	// (sample - floor) * 35 / 10 == (sample - floor) * 7 / 2
	always_comb begin
		diff    = tick.throttle_sample - cfg.throttle_floor;
		diff_x7 = ({3'b000, diff} << 3) - {3'b000, diff};
		scaled  = diff_x7[12:1];
		if (tick.throttle_sample < cfg.throttle_floor) begin
			speed = '0;
		end else if (scaled > {1'b0, SPEED_MAX}) begin
			speed = SPEED_MAX;
		end else begin
			speed = scaled[10:0];
		end
	end

	always_comb begin
		logic [2:0]  flash_mask;
		logic [15:0] fc_inc;
		logic        fire;
		nxt        = cur;
		flash_mask = LED_ON_MASK;
		fire       = 1'b0;
		res        = '0;

		// entry and timeout work ahead of the flash
		unique case (cur.mode)
			MODE_OFF: begin
				flash_mask = LED_OFF_MASK;
				if (cur.entering) begin
					nxt.flash_count = '0;
					nxt.send_count  = '0;
					nxt.on_flag     = 1'b0;
					nxt.entering    = 1'b0;
				end
			end
			MODE_IN_RANGE: begin
				flash_mask = LED_RANGE_MASK;
				if (cur.entering) begin
					nxt.flash_count = '0;
					nxt.send_count  = '0;
					nxt.entering    = 1'b0;
				end
				if (tick.link_timed_out) begin
					nxt.mode     = MODE_OFF;
					nxt.entering = 1'b1;
					nxt.leds     = nxt.leds & ~LED_RANGE_MASK;
				end
			end
			default: begin
				flash_mask = LED_ON_MASK;
				if (cur.entering) begin
					nxt.on_flag  = 1'b1;
					nxt.entering = 1'b0;
				end
				if (tick.link_timed_out) begin
					nxt.leds     = nxt.leds & ~(LED_OFF_MASK | LED_ON_MASK);
					nxt.mode     = MODE_OFF;
					nxt.entering = 1'b1;
				end
			end
		endcase

		// flash counter
		fc_inc = nxt.flash_count + 16'd1;
		if (fc_inc >= cfg.led_flash_period) begin
			nxt.leds        = nxt.leds ^ flash_mask;
			nxt.flash_count = '0;
		end else begin
			nxt.flash_count = fc_inc;
		end

		// button and reply work after the flash
		unique case (cur.mode)
			MODE_OFF: begin
			end
			MODE_IN_RANGE: begin
				if (tick.button_event) begin
					nxt.on_flag = 1'b1;
				end
			end
			default: begin
				res.motor_speed = speed;
				if (tick.button_event) begin
					nxt.on_flag  = 1'b0;
					nxt.mode     = MODE_OFF;
					nxt.entering = 1'b1;
				end
			end
		endcase

		res.status_out = nxt.on_flag ? (8'd1 << cfg.on_bit_index) : 8'd0;

		// send counter
		if (nxt.send_count >= cfg.send_period) begin
			fire           = 1'b1;
			nxt.send_count = '0;
		end
		nxt.send_count = nxt.send_count + 16'd1;

		if (tick.reply_arrived) begin
			if (cur.mode == MODE_OFF && tick.reply_status[cfg.in_range_bit_index]) begin
				nxt.mode     = MODE_IN_RANGE;
				nxt.entering = 1'b1;
				nxt.leds     = nxt.leds & ~LED_OFF_MASK;
			end else if (cur.mode == MODE_IN_RANGE && tick.reply_status[cfg.on_bit_index]) begin
				nxt.mode     = MODE_ON;
				nxt.entering = 1'b1;
				nxt.leds     = nxt.leds & ~LED_RANGE_MASK;
			end
		end

		res.send_now    = fire;
		res.led_pattern = nxt.leds;
		res.mode_out    = nxt.mode;
	end

endmodule

### dv/remote_link_mode_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_link_mode_sequencer_checker
// watches the tick streams and register writes, predicts and compares
// ----------------------------------------------------------------------------
// Keeps its own copy of the mode state and of the five registers. Every tick
// beat taken on the input side is run through the mode update at once and
// the expected result is queued. Every beat taken on the output side is
// compared field by field with the oldest queued result. Counts of errors,
// queued results and a little coverage are handed back to the testbench top.
// ----------------------------------------------------------------------------
module remote_link_mode_sequencer_checker
	import rlms_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	// reply_arrived, reply_status, link_timed_out, button_event, throttle_sample
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// send_now, status_out, motor_speed, led_pattern, mode_out
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    pending,
	output int                    errors,
	output int                    ticks_checked,
	output int                    on_ticks,
	output int                    sends_seen
);

	logic [15:0] flash_period;
	logic [15:0] send_period;
	logic [2:0]  on_bit;
	logic [2:0]  range_bit;
	logic [9:0]  thr_floor;

	mode_t       mode_q;
	logic        entering;
	logic [15:0] flash_cnt;
	logic [15:0] send_cnt;
	logic        on_flag;
	logic [2:0]  leds;

	tick_out_t   expected_ticks[$];
	tick_in_t    tick_in;
	tick_out_t   got;
	tick_out_t   want;
	int          err_cnt;
	int          n_checked;
	int          n_on;
	int          n_sends;

	function automatic void flash_step(input int led);
		flash_cnt = flash_cnt + 16'd1;
		if (flash_cnt >= flash_period) begin
			leds[led] = ~leds[led];
			flash_cnt = '0;
		end
	endfunction

	function automatic logic send_step();
		logic fire;
		fire = (send_cnt >= send_period);
		if (fire)
			send_cnt = '0;
		send_cnt = send_cnt + 16'd1;
		return fire;
	endfunction

	function automatic tick_out_t run_tick(input tick_in_t t);
		tick_out_t r;
		logic [10:0] speed;
		int          scaled;
		speed = '0;
		case (mode_q)
			MODE_OFF: begin
				if (entering) begin
					flash_cnt = '0;
					send_cnt  = '0;
					on_flag   = 1'b0;
					entering  = 1'b0;
				end
				flash_step(0);
				if (t.reply_arrived && t.reply_status[range_bit]) begin
					mode_q   = MODE_IN_RANGE;
					entering = 1'b1;
					leds[0]  = 1'b0;
				end
			end
			MODE_IN_RANGE: begin
				if (entering) begin
					flash_cnt = '0;
					send_cnt  = '0;
					entering  = 1'b0;
				end
				if (t.link_timed_out) begin
					mode_q   = MODE_OFF;
					entering = 1'b1;
					leds[1]  = 1'b0;
				end
				flash_step(1);
				if (t.button_event)
					on_flag = 1'b1;
				// reply is applied after the timeout, so it wins
				if (t.reply_arrived && t.reply_status[on_bit]) begin
					mode_q   = MODE_ON;
					entering = 1'b1;
					leds[1]  = 1'b0;
				end
			end
			default: begin
				if (entering) begin
					on_flag  = 1'b1;
					entering = 1'b0;
				end
				if (t.link_timed_out) begin
					leds[0]  = 1'b0;
					leds[2]  = 1'b0;
					mode_q   = MODE_OFF;
					entering = 1'b1;
				end
				flash_step(2);
				if (t.throttle_sample >= thr_floor) begin
					scaled = (int'(t.throttle_sample) - int'(thr_floor)) * 35 / 10;
					speed  = (scaled > int'(SPEED_MAX)) ? SPEED_MAX : 11'(scaled);
				end
				if (t.button_event) begin
					on_flag  = 1'b0;
					mode_q   = MODE_OFF;
					entering = 1'b1;
				end
			end
		endcase
		r.send_now    = send_step();
		r.status_out  = on_flag ? (8'd1 << on_bit) : 8'd0;
		r.motor_speed = speed;
		r.led_pattern = leds;
		r.mode_out    = mode_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flash_period = RST_LED_FLASH_PERIOD;
			send_period  = RST_SEND_PERIOD;
			on_bit       = RST_ON_BIT_INDEX;
			range_bit    = RST_IN_RANGE_BIT_IDX;
			thr_floor    = RST_THROTTLE_FLOOR;
			mode_q       = MODE_OFF;
			entering     = 1'b1;
			flash_cnt    = '0;
			send_cnt     = '0;
			on_flag      = 1'b0;
			leds         = '0;
			expected_ticks.delete();
			err_cnt      = 0;
			n_checked    = 0;
			n_on         = 0;
			n_sends      = 0;
			pending       <= 0;
			errors        <= 0;
			ticks_checked <= 0;
			on_ticks      <= 0;
			sends_seen    <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LED_FLASH_PERIOD:   flash_period = cfg_wdata[15:0];
					REG_SEND_PERIOD:        send_period  = cfg_wdata[15:0];
					REG_ON_BIT_INDEX:       on_bit       = cfg_wdata[2:0];
					REG_IN_RANGE_BIT_INDEX: range_bit    = cfg_wdata[2:0];
					REG_THROTTLE_FLOOR:     thr_floor    = cfg_wdata[9:0];
					default: ;
				endcase
			end
			// compare before queueing, a result never leaves in the cycle its tick enters
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[$bits(tick_out_t)-1:0];
				if (expected_ticks.size() == 0) begin
					$error("result beat with no tick outstanding: %h", m_axis_tdata);
					err_cnt++;
				end else begin
					want = expected_ticks.pop_front();
					n_checked++;
					if (got.mode_out == MODE_ON)
						n_on++;
					if (got.send_now)
						n_sends++;
					if (got.send_now !== want.send_now) begin
						$error("send_now: expected %0d, got %0d", want.send_now, got.send_now);
						err_cnt++;
					end
					if (got.status_out !== want.status_out) begin
						$error("status_out: expected %h, got %h", want.status_out,
							got.status_out);
						err_cnt++;
					end
					if (got.motor_speed !== want.motor_speed) begin
						$error("motor_speed: expected %0d, got %0d", want.motor_speed,
							got.motor_speed);
						err_cnt++;
					end
					if (got.led_pattern !== want.led_pattern) begin
						$error("led_pattern: expected %b, got %b", want.led_pattern,
							got.led_pattern);
						err_cnt++;
					end
					if (got.mode_out !== want.mode_out) begin
						$error("mode_out: expected %0d, got %0d", want.mode_out,
							got.mode_out);
						err_cnt++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				tick_in = s_axis_tdata[$bits(tick_in_t)-1:0];
				expected_ticks.push_back(run_tick(tick_in));
			end
			pending       <= expected_ticks.size();
			errors        <= err_cnt;
			ticks_checked <= n_checked;
			on_ticks      <= n_on;
			sends_seen    <= n_sends;
		end
	end

endmodule

### dv/remote_link_mode_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_link_mode_sequencer_top_tb
// stimulus and verdict for the remote link mode sequencer
// ----------------------------------------------------------------------------
// Drives tick beats into the block with random gaps and random output stalls.
// A directed run walks every mode change, the ignored events, the combined
// timeout and reply in range mode and the throttle clamp and floor edges.
// Random runs follow under several register settings, the extremes among
// them, each written while the block is idle. The checker beside the block
// predicts and compares; this module only reports its verdict.
// ----------------------------------------------------------------------------
module remote_link_mode_sequencer_top_tb;
	import rlms_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int          pending;
	int          errors;
	int          ticks_checked;
	int          on_ticks;
	int          sends_seen;
	logic        steady;
	logic [9:0]  floor_now;
	int          settings;

	remote_link_mode_sequencer_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	remote_link_mode_sequencer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.pending       (pending),
		.errors        (errors),
		.ticks_checked (ticks_checked),
		.on_ticks      (on_ticks),
		.sends_seen    (sends_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic tick_in_t mk_tick(input logic reply, input logic [7:0] status,
		input logic timeout, input logic button, input logic [9:0] throttle);
		tick_in_t t;
		t.reply_arrived   = reply;
		t.reply_status    = status;
		t.link_timed_out  = timeout;
		t.button_event    = button;
		t.throttle_sample = throttle;
		return t;
	endfunction

	function automatic tick_in_t random_tick();
		tick_in_t t;
		int       near;
		t.reply_arrived  = ($urandom_range(0, 99) < 30);
		t.reply_status   = 8'($urandom);
		t.link_timed_out = ($urandom_range(0, 99) < 8);
		t.button_event   = ($urandom_range(0, 99) < 8);
		case ($urandom_range(0, 3))
			0: t.throttle_sample = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
			1: begin
				near = int'(floor_now) + $urandom_range(0, 16) - 8;
				t.throttle_sample = (near < 0) ? 10'd0 : (near > 1023) ? 10'd1023 : 10'(near);
			end
			default: t.throttle_sample = 10'($urandom);
		endcase
		return t;
	endfunction

	task automatic send_tick(input tick_in_t t);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_DATA_W'(t);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] flash_p, input logic [15:0] send_p,
		input logic [2:0] on_b, input logic [2:0] range_b, input logic [9:0] thr_f);
		logic [CFG_IDX_W-1:0]  idx [5];
		logic [CFG_DATA_W-1:0] val [5];
		idx = '{REG_LED_FLASH_PERIOD, REG_SEND_PERIOD, REG_ON_BIT_INDEX,
			REG_IN_RANGE_BIT_INDEX, REG_THROTTLE_FLOOR};
		val = '{flash_p, send_p, 16'(on_b), 16'(range_b), 16'(thr_f)};
		for (int k = 0; k < 5; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_wdata <= val[k];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		floor_now = thr_f;
		settings++;
	endtask

	// output side: random stall before every result beat, none while steady
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	initial begin
		tick_in_t directed[$];
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_wdata     <= '0;
		steady    = 1'b0;
		floor_now = RST_THROTTLE_FLOOR;
		settings  = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a few ticks under the reset register values
		repeat (6) send_tick(random_tick());
		drain();

		set_regs(16'd3, 16'd2, 3'd0, 3'd1, 10'd370);
		// ignored events in off, replies without the flag bit, then up to on
		directed.push_back(mk_tick(1'b0, 8'hFF, 1'b1, 1'b1, 10'd0));
		directed.push_back(mk_tick(1'b1, 8'hFD, 1'b0, 1'b0, 10'd1023));
		directed.push_back(mk_tick(1'b1, 8'h02, 1'b0, 1'b0, 10'd600));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b1, 10'd512));
		directed.push_back(mk_tick(1'b1, 8'hFE, 1'b0, 1'b0, 10'd0));
		directed.push_back(mk_tick(1'b1, 8'h01, 1'b0, 1'b0, 10'd1023));
		// throttle floor and clamp edges, reply ignored in on
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b0, 10'd0));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b0, 10'd369));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b0, 10'd370));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b0, 10'd371));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b0, 10'd1023));
		directed.push_back(mk_tick(1'b1, 8'hFF, 1'b0, 1'b0, 10'd662));
		// timeout in on, then timeout and on reply together in range
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b1, 1'b0, 10'd700));
		directed.push_back(mk_tick(1'b1, 8'h02, 1'b0, 1'b0, 10'd0));
		directed.push_back(mk_tick(1'b1, 8'h01, 1'b1, 1'b0, 10'd0));
		// button leaves on
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b1, 10'd900));
		// timeout alone in range
		directed.push_back(mk_tick(1'b1, 8'h02, 1'b0, 1'b0, 10'd0));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b1, 1'b0, 10'd0));
		// timeout and button together in on
		directed.push_back(mk_tick(1'b1, 8'h02, 1'b0, 1'b0, 10'd0));
		directed.push_back(mk_tick(1'b1, 8'h01, 1'b0, 1'b0, 10'd800));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b1, 1'b1, 10'd1023));
		directed.push_back(mk_tick(1'b0, 8'h00, 1'b0, 1'b0, 10'd1023));
		foreach (directed[k])
			send_tick(directed[k]);
		drain();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_regs(16'd1, 16'd1, 3'd7, 3'd0, 10'd0);
				1: set_regs(16'hFFFF, 16'hFFFF, 3'd3, 3'd7, 10'd1023);
				// zero periods fire every tick
				2: set_regs(16'd0, 16'd0, 3'd5, 3'd2, 10'd512);
				3: set_regs(16'($urandom_range(1, 20)), 16'($urandom_range(1, 20)),
					3'($urandom), 3'($urandom), 10'($urandom));
				4: set_regs(RST_LED_FLASH_PERIOD, RST_SEND_PERIOD, RST_ON_BIT_INDEX,
					RST_IN_RANGE_BIT_IDX, RST_THROTTLE_FLOOR);
				default: set_regs(16'd2, 16'd3, 3'd6, 3'd4, 10'd100);
			endcase
			for (int i = 0; i < 95; i++) begin
				steady = (i >= 20 && i < 40);
				if (i == 60)
					drain();
				send_tick(random_tick());
			end
			steady = 1'b0;
			drain();
		end

		repeat (8) @(posedge clk);
		$display("%0d ticks checked under %0d register settings", ticks_checked, settings);
		$display("%0d results in on mode, %0d with a packet send", on_ticks, sends_seen);
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
